### design/cc20_pkg.sv
// Package: shared types and constants for the ChaCha20 keystream XOR block.
package cc20_pkg;

   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646e;
   localparam logic [31:0] SIGMA2 = 32'h79622d32;
   localparam logic [31:0] SIGMA3 = 32'h6b206574;

   localparam int RegIdxWidth = 3;
   localparam logic [RegIdxWidth-1:0] REG_KEY0   = 3'd0;
   localparam logic [RegIdxWidth-1:0] REG_KEY1   = 3'd1;
   localparam logic [RegIdxWidth-1:0] REG_KEY2   = 3'd2;
   localparam logic [RegIdxWidth-1:0] REG_KEY3   = 3'd3;
   localparam logic [RegIdxWidth-1:0] REG_NONCEL = 3'd4;
   localparam logic [RegIdxWidth-1:0] REG_NONCEH = 3'd5;
   localparam logic [RegIdxWidth-1:0] REG_CTR    = 3'd6;

   typedef logic [31:0] word_type;
   typedef word_type [15:0] state_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } fsm_type;

   // Control handed down the chain of round cells.
   typedef struct packed {
      logic load;    // load the initial state into the first cell
      logic active;  // cells advance this cycle
   } chain_ctl_type;

   function automatic word_type rotl(input word_type v, input int n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   // One quarter round on four words.
   function automatic logic [127:0] qr(input word_type a_i, input word_type b_i,
                                      input word_type c_i, input word_type d_i);
      word_type a, b, c, d;
      a = a_i; b = b_i; c = c_i; d = d_i;
      a = a + b; d = rotl(d ^ a, 16);
      c = c + d; b = rotl(b ^ c, 12);
      a = a + b; d = rotl(d ^ a, 8);
      c = c + d; b = rotl(b ^ c, 7);
      qr = {d, c, b, a};
   endfunction

endpackage

### design/cc20_round_cell.sv
// One round cell: holds a 16-word state and applies a column or diagonal round.
module cc20_round_cell #(
   parameter bit DIAGONAL = 1'b0
) (
   input  logic                 clock,
   input  cc20_pkg::chain_ctl_type ctl,
   input  cc20_pkg::state_type  state_i,
   output cc20_pkg::state_type  state_o
);
   import cc20_pkg::*;

   state_type st_ff;
   state_type st_in;

   // Four quarter rounds in parallel on the incoming state
   always_comb begin
      logic [127:0] q0, q1, q2, q3;
      st_in = state_i;
      if (!DIAGONAL) begin
         q0 = qr(state_i[0], state_i[4], state_i[8],  state_i[12]);
         q1 = qr(state_i[1], state_i[5], state_i[9],  state_i[13]);
         q2 = qr(state_i[2], state_i[6], state_i[10], state_i[14]);
         q3 = qr(state_i[3], state_i[7], state_i[11], state_i[15]);
         {st_in[12], st_in[8],  st_in[4], st_in[0]} = q0;
         {st_in[13], st_in[9],  st_in[5], st_in[1]} = q1;
         {st_in[14], st_in[10], st_in[6], st_in[2]} = q2;
         {st_in[15], st_in[11], st_in[7], st_in[3]} = q3;
      end else begin
         q0 = qr(state_i[0], state_i[5], state_i[10], state_i[15]);
         q1 = qr(state_i[1], state_i[6], state_i[11], state_i[12]);
         q2 = qr(state_i[2], state_i[7], state_i[8],  state_i[13]);
         q3 = qr(state_i[3], state_i[4], state_i[9],  state_i[14]);
         {st_in[15], st_in[10], st_in[5], st_in[0]} = q0;
         {st_in[12], st_in[11], st_in[6], st_in[1]} = q1;
         {st_in[13], st_in[8],  st_in[7], st_in[2]} = q2;
         {st_in[14], st_in[9],  st_in[4], st_in[3]} = q3;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.active) st_ff <= st_in;
   end

   assign state_o = st_ff;
endmodule

### design/cc20_round_chain.sv
// Chain of round cells: a ring of column/diagonal cells cycled for the double rounds.
module cc20_round_chain (
   input  logic                    clock,
   input  cc20_pkg::chain_ctl_type ctl,
   input  cc20_pkg::state_type     init_i,
   output cc20_pkg::state_type     state_o
);
   import cc20_pkg::*;

   state_type col_out, diag_out, col_in;

   // The first cell takes the initial state on load, else the diagonal result
   assign col_in = ctl.load ? init_i : diag_out;

   cc20_round_cell #(.DIAGONAL(1'b0)) u_col (
      .clock(clock), .ctl(ctl), .state_i(col_in), .state_o(col_out));

   cc20_round_cell #(.DIAGONAL(1'b1)) u_diag (
      .clock(clock), .ctl(ctl), .state_i(col_out), .state_o(diag_out));

   assign state_o = diag_out;
endmodule

### design/chacha20_keystream_xor.sv
// Top level: ChaCha20 keystream XOR, one byte per request.
// A byte that opens a block loads the two-cell round ring and gives its result
//   after the round steps (ST_ROUND), the add of the initial state (ST_ADD) and the
//   output state (ST_OUT); other bytes of the block are registered straight to the output.
//   Throughput: one byte per cycle within a block while rsp_tready does not stall the output.
// Reset (synchronous, active high) clears the counters and the handshake;
//   keys, nonce and counter take their documented reset values.
module chacha20_keystream_xor #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // result_byte
   output logic        rsp_tlast,   // result_last
   input  logic        csr_we,
   input  logic [cc20_pkg::RegIdxWidth-1:0] csr_index,
   input  logic [63:0] csr_wdata
);
   import cc20_pkg::*;

   localparam int RcW = $clog2(2 * DOUBLE_ROUNDS);

   logic [63:0] key_ff [4];
   logic [63:0] nonce_lo_ff;
   logic [31:0] nonce_hi_ff, ctr_init_ff;
   logic [31:0] blk_off_ff, blk_off_in;
   logic [5:0]  pos_ff, pos_in;
   state_type   ks_ff, init_ff, init_in;
   fsm_type     st_ff, st_in;
   logic [RcW-1:0] rc_ff, rc_in;
   logic [7:0]  dat_ff;
   logic        last_ff;
   logic        ovalid_ff, ovalid_in;
   logic [7:0]  obyte_ff, obyte_in;
   logic        olast_ff, olast_in;
   chain_ctl_type ctl;
   state_type   chain_out;
   logic        acc, out_free, ks_load;
   word_type    ks_word;
   logic [7:0]  ks_byte;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         nonce_lo_ff <= '0;
         nonce_hi_ff <= '0;
         ctr_init_ff <= 32'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_KEY0:   key_ff[0] <= csr_wdata;
            REG_KEY1:   key_ff[1] <= csr_wdata;
            REG_KEY2:   key_ff[2] <= csr_wdata;
            REG_KEY3:   key_ff[3] <= csr_wdata;
            REG_NONCEL: nonce_lo_ff <= csr_wdata;
            REG_NONCEH: nonce_hi_ff <= csr_wdata[31:0];
            REG_CTR:    ctr_init_ff <= csr_wdata[31:0];
            default:    ;
         endcase
      end
   end

   // Initial block state
   always_comb begin
      init_in[0] = SIGMA0; init_in[1] = SIGMA1;
      init_in[2] = SIGMA2; init_in[3] = SIGMA3;
      for (int i = 0; i < 8; i++) init_in[4+i] = key_ff[i/2][32*(i%2) +: 32];
      init_in[12] = ctr_init_ff + blk_off_ff;
      init_in[13] = nonce_lo_ff[31:0];
      init_in[14] = nonce_lo_ff[63:32];
      init_in[15] = nonce_hi_ff;
   end

   assign out_free = !ovalid_ff || rsp_tready;
   assign req_tready = (st_ff == ST_IDLE) && out_free;
   assign acc = req_tvalid && req_tready;

   assign ctl.load   = (st_ff == ST_IDLE) && acc && (pos_ff == 6'd0);
   assign ctl.active = ctl.load || (st_ff == ST_ROUND);

   cc20_round_chain u_chain (
      .clock(clock), .ctl(ctl), .init_i(init_in), .state_o(chain_out));

   // Next state: ST_ROUND counts ring steps in rc_ff until the ring finishes the last diagonal round
   always_comb begin
      st_in = st_ff;
      rc_in = rc_ff;
      case (st_ff)
         ST_IDLE: if (ctl.load) begin
            st_in = ST_ROUND;
            rc_in = RcW'(1);
         end
         ST_ROUND: begin
            if (rc_ff == RcW'(2 * DOUBLE_ROUNDS - 1)) st_in = ST_ADD;
            else rc_in = rc_ff + RcW'(1);
         end
         ST_ADD:  st_in = ST_OUT;
         ST_OUT:  if (out_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // Outputs and bookkeeping
   assign ks_load = (st_ff == ST_ADD);
   always_comb begin
      logic [5:0] p;
      logic       l;
      logic       fire;
      ovalid_in = ovalid_ff && !rsp_tready;
      obyte_in  = obyte_ff;
      olast_in  = olast_ff;
      pos_in    = pos_ff;
      blk_off_in = blk_off_ff;
      fire = 1'b0;
      p = pos_ff;
      l = req_tlast;
      ks_word = ks_ff[p[5:2]];
      if (st_ff == ST_IDLE && acc && pos_ff != 6'd0) begin
         fire = 1'b1;
         obyte_in = req_tdata ^ ks_word[8*p[1:0] +: 8];
      end else if (st_ff == ST_OUT && out_free) begin
         fire = 1'b1;
         l = last_ff;
         obyte_in = dat_ff ^ ks_ff[0][7:0];
      end
      if (fire) begin
         ovalid_in = 1'b1;
         olast_in  = l;
         pos_in    = l ? 6'd0 : pos_ff + 6'd1;
         if (l) blk_off_in = '0;
      end
      if (ctl.load) blk_off_in = blk_off_ff + 32'd1;
   end
   assign ks_byte = obyte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_IDLE;
         rc_ff      <= '0;
         ovalid_ff  <= 1'b0;
         pos_ff     <= '0;
         blk_off_ff <= '0;
      end else begin
         st_ff      <= st_in;
         rc_ff      <= rc_in;
         ovalid_ff  <= ovalid_in;
         pos_ff     <= pos_in;
         blk_off_ff <= blk_off_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
      if (ctl.load) begin
         init_ff <= init_in;
         dat_ff  <= req_tdata;
         last_ff <= req_tlast;
      end
      if (ks_load) begin
         for (int i = 0; i < 16; i++) ks_ff[i] <= chain_out[i] + init_ff[i];
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = ks_byte;
   assign rsp_tlast  = olast_ff;
endmodule
